// File: rtl/vnc_pkg.sv
// ----------------------------------------------------------------------------
// vnc_pkg: shared types and constants for the vector normalise/cross unit
// Field widths and result limits used by the lanes and the top level.
// ----------------------------------------------------------------------------
`default_nettype none
package vnc_pkg;
    localparam int COMP_W   = 32;
    localparam int RES_W    = 64;
    localparam int Q_BITS   = 32;
    localparam int E_W      = 130;
    localparam int T_W      = 97;

    typedef enum logic { REQ_NORM = 1'b0, REQ_CROSS = 1'b1 } req_t;

    typedef logic signed [RES_W-1:0] res_t;

    localparam res_t RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam res_t RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // a - b with saturation to the signed 64-bit range
    function automatic res_t sat_sub(input res_t a, input res_t b);
        logic signed [RES_W:0] d;
        res_t r;
        d = {a[RES_W-1], a} - {b[RES_W-1], b};
        if (d[RES_W] != d[RES_W-1])
        begin
            r = d[RES_W] ? RES_MIN : RES_MAX;
        end
        else
        begin
            r = d[RES_W-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/vnc_lane.sv
// ----------------------------------------------------------------------------
// vnc_lane: one normalise lane
// Exact floor(m * 2^32 / sqrt(S)) by a 32-stage restoring pipeline, one
// quotient bit per stage, using only shifts and adds on the running residue.
// ----------------------------------------------------------------------------
`default_nettype none
module vnc_lane
    import vnc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [63:0] sq,
    input  wire logic [63:0] s,
    input  wire logic        neg,
    output res_t             q
);
    // residue E = m^2*2^64 - r^2*S, T = r*S
    logic [E_W-1:0]    e_reg [0:Q_BITS-1];
    logic [T_W-1:0]    t_reg [0:Q_BITS-1];
    logic [Q_BITS-1:0] r_reg [0:Q_BITS-1];
    logic [63:0]       s_reg [0:Q_BITS-1];
    logic              neg_reg [0:Q_BITS-1];
    logic              eq_reg  [0:Q_BITS-1];

    genvar i;
    generate
        for (i = 0; i < Q_BITS; i++)
        begin : g_stage
            localparam int K = Q_BITS - 1 - i;
            logic [E_W-1:0]    e_prev, d, e_next;
            logic [T_W-1:0]    t_prev, t_next;
            logic [Q_BITS-1:0] r_prev, r_next;
            logic [63:0]       s_prev;
            logic              neg_prev, eq_prev;

            if (i == 0)
            begin : g_first
                assign e_prev   = {2'b0, sq, 64'b0};
                assign t_prev   = '0;
                assign r_prev   = '0;
                assign s_prev   = s;
                assign neg_prev = neg;
                assign eq_prev  = (sq == s);
            end
            else
            begin : g_rest
                assign e_prev   = e_reg[i-1];
                assign t_prev   = t_reg[i-1];
                assign r_prev   = r_reg[i-1];
                assign s_prev   = s_reg[i-1];
                assign neg_prev = neg_reg[i-1];
                assign eq_prev  = eq_reg[i-1];
            end

            always_comb
            begin
                d = ({{(E_W-T_W){1'b0}}, t_prev} << (K + 1))
                  + ({{(E_W-64){1'b0}}, s_prev} << (2 * K));
                if (d <= e_prev)
                begin
                    e_next = e_prev - d;
                    t_next = t_prev + T_W'({{(T_W-64){1'b0}}, s_prev} << K);
                    r_next = r_prev | (Q_BITS'(1) << K);
                end
                else
                begin
                    e_next = e_prev;
                    t_next = t_prev;
                    r_next = r_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                e_reg[i]   <= e_next;
                t_reg[i]   <= t_next;
                r_reg[i]   <= r_next;
                s_reg[i]   <= s_prev;
                neg_reg[i] <= neg_prev;
                eq_reg[i]  <= eq_prev;
            end
        end
    endgenerate

    logic [RES_W-1:0] mag;
    always_comb
    begin
        // |c| equal to the length gives exactly 1.0
        mag = eq_reg[Q_BITS-1] ? (RES_W'(1) << Q_BITS)
                               : {{(RES_W-Q_BITS){1'b0}}, r_reg[Q_BITS-1]};
        q   = neg_reg[Q_BITS-1] ? res_t'(-mag) : res_t'(mag);
    end
endmodule
`default_nettype wire

// File: rtl/vector3_normalize_cross_unit.sv
// ----------------------------------------------------------------------------
// vector3_normalize_cross_unit: 3D vector normalise and cross product
// Q16.16 inputs, saturated Q32.32 results, one transaction per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low.
//   busy is always low: the pipeline takes a new transaction every cycle.
//   req_type 0 normalises a (b ignored); req_type 1 gives a x b.
//   Each transaction yields one result, shown for one cycle with done high.
//   From acceptance to the done cycle a transaction passes through the
//   squares/products register, the sum and difference register, 32
//   quotient-bit stages in the three normalise lanes (x, y, z side by
//   side), and the output merge register. Throughput is one transaction
//   per cycle, set by the fully pipelined lanes.
//   A zero vector on normalise gives zero components and zero_length high.
//   Reset clears the valid pipeline only; no result is issued until fresh
//   transactions arrive. The receiver cannot stall; results must be taken.
// ----------------------------------------------------------------------------
`default_nettype none
module vector3_normalize_cross_unit
    import vnc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     req_type,
    input  wire logic signed [COMP_W-1:0] ax,
    input  wire logic signed [COMP_W-1:0] ay,
    input  wire logic signed [COMP_W-1:0] az,
    input  wire logic signed [COMP_W-1:0] bx,
    input  wire logic signed [COMP_W-1:0] by_comp,
    input  wire logic signed [COMP_W-1:0] bz,
    output logic                          done,
    output res_t                          res_x,
    output res_t                          res_y,
    output res_t                          res_z,
    output logic                          zero_length
);
    localparam int DLY = Q_BITS;

    assign busy = 1'b0;

    // stage 1: magnitudes squared and the six cross products
    logic [COMP_W-1:0] mx, my, mz;
    logic [63:0] sq1_reg [0:2];
    logic        neg1_reg [0:2];
    res_t        p1_reg [0:5];
    req_t        type1_reg;
    logic        v1_reg;

    always_comb
    begin
        mx = ax[COMP_W-1] ? COMP_W'(-ax) : COMP_W'(ax);
        my = ay[COMP_W-1] ? COMP_W'(-ay) : COMP_W'(ay);
        mz = az[COMP_W-1] ? COMP_W'(-az) : COMP_W'(az);
    end

    always_ff @(posedge clk)
    begin
        sq1_reg[0]  <= mx * mx;
        sq1_reg[1]  <= my * my;
        sq1_reg[2]  <= mz * mz;
        neg1_reg[0] <= ax[COMP_W-1];
        neg1_reg[1] <= ay[COMP_W-1];
        neg1_reg[2] <= az[COMP_W-1];
        p1_reg[0]   <= ay * bz;
        p1_reg[1]   <= az * by_comp;
        p1_reg[2]   <= az * bx;
        p1_reg[3]   <= ax * bz;
        p1_reg[4]   <= ax * by_comp;
        p1_reg[5]   <= ay * bx;
        type1_reg   <= req_t'(req_type);
    end

    // stage 2: squared length and saturated differences
    logic [63:0] sq2_reg [0:2];
    logic        neg2_reg [0:2];
    logic [63:0] s2_reg;
    res_t        c2_reg [0:2];
    req_t        type2_reg;
    logic        v2_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            sq2_reg[j]  <= sq1_reg[j];
            neg2_reg[j] <= neg1_reg[j];
        end
        s2_reg    <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        c2_reg[0] <= sat_sub(p1_reg[0], p1_reg[1]);
        c2_reg[1] <= sat_sub(p1_reg[2], p1_reg[3]);
        c2_reg[2] <= sat_sub(p1_reg[4], p1_reg[5]);
        type2_reg <= type1_reg;
    end

    // normalise lanes, one per component
    res_t nq [0:2];
    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            vnc_lane u_lane
            (
                .clk (clk),
                .sq  (sq2_reg[g]),
                .s   (s2_reg),
                .neg (neg2_reg[g]),
                .q   (nq[g])
            );
        end
    endgenerate

    // cross results and request tags follow the lanes' latency
    res_t cd_reg [0:DLY-1][0:2];
    req_t td_reg [0:DLY-1];
    logic zd_reg [0:DLY-1];
    logic vd_reg [0:DLY-1];

    always_ff @(posedge clk)
    begin
        cd_reg[0] <= c2_reg;
        td_reg[0] <= type2_reg;
        zd_reg[0] <= (s2_reg == 64'd0);
        for (int j = 1; j < DLY; j++)
        begin
            cd_reg[j] <= cd_reg[j-1];
            td_reg[j] <= td_reg[j-1];
            zd_reg[j] <= zd_reg[j-1];
        end
    end

    // valid pipeline, the only state that reset clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int j = 0; j < DLY; j++)
            begin
                vd_reg[j] <= 1'b0;
            end
            done <= 1'b0;
        end
        else
        begin
            v1_reg    <= start & ~busy;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int j = 1; j < DLY; j++)
            begin
                vd_reg[j] <= vd_reg[j-1];
            end
            done <= vd_reg[DLY-1];
        end
    end

    // merge: pick the cross or normalise result
    always_ff @(posedge clk)
    begin
        unique case (td_reg[DLY-1])
            REQ_CROSS:
            begin
                res_x       <= cd_reg[DLY-1][0];
                res_y       <= cd_reg[DLY-1][1];
                res_z       <= cd_reg[DLY-1][2];
                zero_length <= 1'b0;
            end
            REQ_NORM:
            begin
                if (zd_reg[DLY-1])
                begin
                    res_x <= '0;
                    res_y <= '0;
                    res_z <= '0;
                end
                else
                begin
                    res_x <= nq[0];
                    res_y <= nq[1];
                    res_z <= nq[2];
                end
                zero_length <= zd_reg[DLY-1];
            end
            default:
            begin
                res_x       <= '0;
                res_y       <= '0;
                res_z       <= '0;
                zero_length <= 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector3_normalize_cross_unit
// Queue-fed driver, strobe monitor, in-bench predictor of normalise and
// cross results, compared field by field in transaction order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench
    import vnc_pkg::*;
();

    localparam int LATENCY   = 35;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1300;

    typedef struct packed {
        req_t              kind;
        logic signed [31:0] ax, ay, az, bx, by, bz;
    } vec_req_t;

    typedef struct packed {
        res_t rx, ry, rz;
        logic zl;
    } vec_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic req_type = 1'b0;
    logic signed [31:0] ax = '0, ay = '0, az = '0, bx = '0, by_comp = '0, bz = '0;
    wire logic busy, done, zero_length;
    res_t res_x, res_y, res_z;

    vector3_normalize_cross_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .ax(ax), .ay(ay), .az(az),
        .bx(bx), .by_comp(by_comp), .bz(bz),
        .done(done), .res_x(res_x), .res_y(res_y), .res_z(res_z),
        .zero_length(zero_length)
    );

    always #6 clk = ~clk;

    vec_req_t pending_reqs[$];
    vec_res_t expected_results[$];
    int  idle_pct = 0;          // sender idle share for the current phase
    bit  hold_drain = 1'b0;     // sender waits for every result to arrive
    int  mismatches = 0;
    int  wdog = 0;

    // floor(m * 2^32 / sqrt(s)) with m^2 <= s, bit by bit on wide integers
    function automatic logic [63:0] unit_magnitude(input logic [63:0] m,
                                                   input logic [63:0] s);
        logic [127:0] msq_shift;
        logic [127:0] trial;
        logic [32:0]  q;
        logic [32:0]  c;
        msq_shift = {m * m, 64'd0};
        q = '0;
        for (int b = 32; b >= 0; b--)
        begin
            c = q | (33'd1 << b);
            trial = {95'd0, c} * {95'd0, c} * {64'd0, s};
            if (trial <= msq_shift)
                q = c;
        end
        return {31'd0, q};
    endfunction

    function automatic logic [63:0] abs32(input logic signed [31:0] v);
        return v < 0 ? 64'(-64'(v)) : 64'(v);
    endfunction

    function automatic res_t signed_unit(input logic signed [31:0] v,
                                         input logic [63:0] s);
        logic [63:0] q;
        q = unit_magnitude(abs32(v), s);
        return v < 0 ? res_t'(-q) : res_t'(q);
    endfunction

    function automatic res_t cross_term(input logic signed [31:0] p1,
                                        input logic signed [31:0] p2,
                                        input logic signed [31:0] q1,
                                        input logic signed [31:0] q2);
        logic signed [65:0] d;
        d = 66'(p1) * 66'(p2) - 66'(q1) * 66'(q2);
        if (d > 66'sh0_7FFF_FFFF_FFFF_FFFF)
            return RES_MAX;
        if (d < -66'sh0_8000_0000_0000_0000)
            return RES_MIN;
        return d[63:0];
    endfunction

    function automatic vec_res_t predict_vector(input vec_req_t r);
        vec_res_t o;
        logic [63:0] s;
        o = '0;
        if (r.kind == REQ_NORM)
        begin
            s = abs32(r.ax) * abs32(r.ax) + abs32(r.ay) * abs32(r.ay)
                + abs32(r.az) * abs32(r.az);
            if (s == 0)
                o.zl = 1'b1;
            else
            begin
                o.rx = signed_unit(r.ax, s);
                o.ry = signed_unit(r.ay, s);
                o.rz = signed_unit(r.az, s);
            end
        end
        else
        begin
            o.rx = cross_term(r.ay, r.bz, r.az, r.by);
            o.ry = cross_term(r.az, r.bx, r.ax, r.bz);
            o.rz = cross_term(r.ax, r.by, r.ay, r.bx);
        end
        return o;
    endfunction

    // Driver: presents items on the falling edge; start held across back-to-back
    // transactions, so it is assigned once per step only.
    always @(negedge clk)
    begin
        vec_req_t r;
        bit go;
        go = rst_n && pending_reqs.size() > 0 && !(hold_drain && expected_results.size() > 0)
             && ($urandom_range(99) >= idle_pct);
        if (start && !busy)
        begin
            // transaction taken at the last rising edge
        end
        if (go)
        begin
            r = pending_reqs.pop_front();
            req_type <= r.kind;
            ax <= r.ax; ay <= r.ay; az <= r.az;
            bx <= r.bx; by_comp <= r.by; bz <= r.bz;
            expected_results.push_back(predict_vector(r));
        end
        start <= go;
    end

    // Monitor and watchdog: sample at the rising edge.
    always @(posedge clk)
    begin
        vec_res_t e;
        if (rst_n)
        begin
            wdog <= (done || (start && !busy)) ? 0 : wdog + 1;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result x=%h y=%h z=%h zl=%b",
                                 res_x, res_y, res_z, zero_length);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.rx !== res_x || e.ry !== res_y || e.rz !== res_z
                        || e.zl !== zero_length)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp %h %h %h %b got %h %h %h %b",
                                     e.rx, e.ry, e.rz, e.zl,
                                     res_x, res_y, res_z, zero_length);
                    end
                end
            end
            if (wdog >= WDOG_MAX)
            begin
                $display("FAIL vector3_normalize_cross_unit");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed(32'($urandom_range(15))) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input req_t k, input logic signed [31:0] a0, a1, a2,
                           input logic signed [31:0] b0, b1, b2);
        vec_req_t r;
        r.kind = k; r.ax = a0; r.ay = a1; r.az = a2;
        r.bx = b0; r.by = b1; r.bz = b2;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [31:0] mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: zero vector, axes, extremes, b ignored on normalise
        add_req(REQ_NORM, 0, 0, 0, mx, mn, 5);
        add_req(REQ_NORM, 0, 0, 0, 0, 0, 0);
        add_req(REQ_NORM, 32'sh1_0000, 0, 0, 0, 0, 0);
        add_req(REQ_NORM, 0, -32'sh1_0000, 0, 1, 2, 3);
        add_req(REQ_NORM, 0, 0, mn, 0, 0, 0);
        add_req(REQ_NORM, mn, mn, mn, 0, 0, 0);
        add_req(REQ_NORM, mx, mx, mx, 0, 0, 0);
        add_req(REQ_NORM, mx, mn, 1, mn, mx, 0);
        add_req(REQ_NORM, 3, 4, 0, 0, 0, 0);
        add_req(REQ_NORM, 1, 1, 1, 0, 0, 0);
        add_req(REQ_NORM, -1, 0, 0, 0, 0, 0);
        add_req(REQ_CROSS, 0, 0, 0, 0, 0, 0);
        add_req(REQ_CROSS, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0);
        add_req(REQ_CROSS, mn, mn, mn, mn, mn, mn);
        add_req(REQ_CROSS, mn, mn, mn, mx, mx, mx);
        // x term mn*mn - mx*mx = 2^32 - 1, within range
        add_req(REQ_CROSS, 0, mn, mx, 0, mx, mn);
        add_req(REQ_CROSS, 0, mn, 1, 0, mx, mn);
        add_req(REQ_CROSS, mx, mx, mx, mn, mn, mn);
        add_req(REQ_CROSS, mx, mn, 0, mn, mx, 0);
        add_req(REQ_CROSS, -1, 2, -3, 4, -5, 6);
        wait_drain();

        // random phases: no idling, heavy gaps, lighter gaps, then a full drain pause
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 66 : (ph == 2) ? 31 : 0;
            for (int i = 0; i < N_RANDOM / 4; i++)
            begin
                if (ph == 3 && i == N_RANDOM / 8)
                begin
                    wait_drain();
                    hold_drain = 1'b1;
                end
                add_req($urandom_range(1) ? REQ_CROSS : REQ_NORM,
                        rand_comp(), rand_comp(), rand_comp(),
                        rand_comp(), rand_comp(), rand_comp());
                if (ph == 3 && i == N_RANDOM / 8)
                begin
                    wait_drain();
                    hold_drain = 1'b0;
                end
            end
            wait_drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS vector3_normalize_cross_unit");
        else
            $display("FAIL vector3_normalize_cross_unit");
        $finish;
    end
endmodule
`default_nettype wire

// File: vector3_normalize_cross_unit.f
rtl/vnc_pkg.sv
rtl/vnc_lane.sv
rtl/vector3_normalize_cross_unit.sv
tb/testbench.sv
